// ===== src/kcl_pkg.sv =====
`default_nettype none

package kcl_pkg;

    localparam int unsigned KEY_W      = 8;
    localparam int unsigned LINES_W    = 8;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned NUM_DIGITS = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_KEY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SECOND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_THIRD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOURTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIFTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_PATTERN = 3'd6;

    // Reset values: '#', '1' to '5' and the first inside line.
    localparam logic [KEY_W-1:0]   START_KEY_RST    = 8'h23;
    localparam logic [KEY_W-1:0]   CODE_FIRST_RST   = 8'h31;
    localparam logic [KEY_W-1:0]   CODE_SECOND_RST  = 8'h32;
    localparam logic [KEY_W-1:0]   CODE_THIRD_RST   = 8'h33;
    localparam logic [KEY_W-1:0]   CODE_FOURTH_RST  = 8'h34;
    localparam logic [KEY_W-1:0]   CODE_FIFTH_RST   = 8'h35;
    localparam logic [LINES_W-1:0] LOCK_PATTERN_RST = 8'h01;

    typedef enum logic [STEP_W-1:0] {
        ST_WAIT   = 4'd0,
        ST_REL0   = 4'd1,
        ST_PRESS1 = 4'd2,
        ST_REL1   = 4'd3,
        ST_PRESS2 = 4'd4,
        ST_REL2   = 4'd5,
        ST_PRESS3 = 4'd6,
        ST_REL3   = 4'd7,
        ST_PRESS4 = 4'd8,
        ST_REL4   = 4'd9,
        ST_PRESS5 = 4'd10,
        ST_REL5   = 4'd11,
        ST_LOCK   = 4'd12
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]                   start_key;
        logic [NUM_DIGITS-1:0][KEY_W-1:0]   code;
        logic [LINES_W-1:0]                 lock_pattern;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/kcl_cfg_regs.sv =====
`default_nettype none

module kcl_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [kcl_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [kcl_pkg::CFG_DATA_W-1:0]   wr_data,
    output kcl_pkg::cfg_t                         cfg
);

    kcl_pkg::cfg_t cfg_reg;
    kcl_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                kcl_pkg::CFG_START_KEY:    cfg_next.start_key    = wr_data;
                kcl_pkg::CFG_CODE_FIRST:   cfg_next.code[0]      = wr_data;
                kcl_pkg::CFG_CODE_SECOND:  cfg_next.code[1]      = wr_data;
                kcl_pkg::CFG_CODE_THIRD:   cfg_next.code[2]      = wr_data;
                kcl_pkg::CFG_CODE_FOURTH:  cfg_next.code[3]      = wr_data;
                kcl_pkg::CFG_CODE_FIFTH:   cfg_next.code[4]      = wr_data;
                kcl_pkg::CFG_LOCK_PATTERN: cfg_next.lock_pattern = wr_data;
                default:                   cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_key    <= kcl_pkg::START_KEY_RST;
            cfg_reg.code[0]      <= kcl_pkg::CODE_FIRST_RST;
            cfg_reg.code[1]      <= kcl_pkg::CODE_SECOND_RST;
            cfg_reg.code[2]      <= kcl_pkg::CODE_THIRD_RST;
            cfg_reg.code[3]      <= kcl_pkg::CODE_FOURTH_RST;
            cfg_reg.code[4]      <= kcl_pkg::CODE_FIFTH_RST;
            cfg_reg.lock_pattern <= kcl_pkg::LOCK_PATTERN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/kcl_seq.sv =====
`default_nettype none

module kcl_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [kcl_pkg::KEY_W-1:0]     key_code,
    input  wire logic [kcl_pkg::LINES_W-1:0]   inside_lines,
    input  wire kcl_pkg::cfg_t                 cfg,
    output logic                               unlocked_next,
    output kcl_pkg::state_t                    step_next
);

    kcl_pkg::state_t          state_reg;
    logic                     latch_reg;
    logic [kcl_pkg::KEY_W-1:0] digit;
    logic                     digit_hit;
    logic                     start_hit;
    logic                     lock_req;

    // Each press/release pair compares against its own code digit.
    always_comb
    begin
        case (state_reg)
            kcl_pkg::ST_PRESS1, kcl_pkg::ST_REL1: digit = cfg.code[0];
            kcl_pkg::ST_PRESS2, kcl_pkg::ST_REL2: digit = cfg.code[1];
            kcl_pkg::ST_PRESS3, kcl_pkg::ST_REL3: digit = cfg.code[2];
            kcl_pkg::ST_PRESS4, kcl_pkg::ST_REL4: digit = cfg.code[3];
            kcl_pkg::ST_PRESS5, kcl_pkg::ST_REL5: digit = cfg.code[4];
            default:                              digit = cfg.code[0];
        endcase
    end

    assign digit_hit = (key_code == digit);
    assign start_hit = (key_code == cfg.start_key);
    assign lock_req  = (inside_lines == cfg.lock_pattern);

    // Next state. In a press state the digit wins over the lock request,
    // which in turn wins over the start key.
    always_comb
    begin
        case (state_reg)
            kcl_pkg::ST_WAIT:
            begin
                if (start_hit)
                    step_next = kcl_pkg::ST_REL0;
                else if (lock_req)
                    step_next = kcl_pkg::ST_LOCK;
                else
                    step_next = kcl_pkg::ST_WAIT;
            end
            kcl_pkg::ST_REL0:
                step_next = start_hit ? kcl_pkg::ST_REL0 : kcl_pkg::ST_PRESS1;
            kcl_pkg::ST_LOCK:
                step_next = lock_req ? kcl_pkg::ST_LOCK : kcl_pkg::ST_WAIT;
            kcl_pkg::ST_PRESS1, kcl_pkg::ST_PRESS2, kcl_pkg::ST_PRESS3,
            kcl_pkg::ST_PRESS4, kcl_pkg::ST_PRESS5:
            begin
                if (digit_hit)
                    step_next = kcl_pkg::state_t'(state_reg + 4'd1);
                else if (lock_req)
                    step_next = kcl_pkg::ST_LOCK;
                else if (start_hit)
                    step_next = kcl_pkg::ST_WAIT;
                else
                    step_next = state_reg;
            end
            kcl_pkg::ST_REL1, kcl_pkg::ST_REL2, kcl_pkg::ST_REL3, kcl_pkg::ST_REL4:
                step_next = digit_hit ? state_reg : kcl_pkg::state_t'(state_reg + 4'd1);
            kcl_pkg::ST_REL5:
                step_next = digit_hit ? kcl_pkg::ST_REL5 : kcl_pkg::ST_PRESS5;
            default:
                step_next = kcl_pkg::ST_WAIT;
        endcase
    end

    // The latch follows the state the tick begins in.
    always_comb
    begin
        case (state_reg)
            kcl_pkg::ST_REL5: unlocked_next = 1'b1;
            kcl_pkg::ST_LOCK: unlocked_next = 1'b0;
            default:          unlocked_next = latch_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kcl_pkg::ST_WAIT;
            latch_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= step_next;
            latch_reg <= unlocked_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/keypad_code_lock.sv =====
// Channel   Handshake                 Payload
// tick      tick_valid / tick_stall   key_code, inside_lines
// result    result_valid / result_stall  unlocked, sequence_step
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One tick is taken every cycle while tick_stall is low; it waits in the input register and
// goes through the sequencer into the result register once the result register is free.
// The sequencer state updates as a tick leaves the input register, so ticks follow back to back.
// Reset clears the pipeline, the sequencer and the configuration to its defaults; cfg_ready is
// always high. A stalled result holds the result register, and the input register takes one
// more beat before tick_stall rises.
`default_nettype none

module keypad_code_lock (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             tick_valid,
    output logic                                  tick_stall,
    input  wire logic [kcl_pkg::KEY_W-1:0]        key_code,
    input  wire logic [kcl_pkg::LINES_W-1:0]      inside_lines,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic                                  unlocked,
    output logic [kcl_pkg::STEP_W-1:0]            sequence_step,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kcl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    kcl_pkg::cfg_t                  cfg;
    logic                           in_valid_reg;
    logic [kcl_pkg::KEY_W-1:0]      key_code_reg;
    logic [kcl_pkg::LINES_W-1:0]    inside_lines_reg;
    logic                           result_valid_reg;
    logic                           unlocked_reg;
    logic [kcl_pkg::STEP_W-1:0]     sequence_step_reg;
    logic                           out_free;
    logic                           advance;
    logic                           accept;
    logic                           unlocked_next;
    kcl_pkg::state_t                step_next;

    assign out_free   = !result_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_free;
    assign tick_stall = in_valid_reg && !out_free;
    assign accept     = tick_valid && !tick_stall;
    assign cfg_ready  = 1'b1;

    kcl_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kcl_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .key_code      (key_code_reg),
        .inside_lines  (inside_lines_reg),
        .cfg           (cfg),
        .unlocked_next (unlocked_next),
        .step_next     (step_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_code_reg     <= key_code;
            inside_lines_reg <= inside_lines;
        end
        if (advance)
        begin
            unlocked_reg      <= unlocked_next;
            sequence_step_reg <= step_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign unlocked      = unlocked_reg;
    assign sequence_step = sequence_step_reg;

endmodule

`default_nettype wire

// ===== src/kcl_checker.sv =====
`default_nettype none

module kcl_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             tick_stall,
    input  wire logic                             result_valid,
    input  wire logic                             result_stall,
    input  wire logic                             unlocked,
    input  wire logic [kcl_pkg::STEP_W-1:0]       sequence_step
);

    // A stalled result beat stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(unlocked)
                                          && $stable(sequence_step))
        else $error("stalled result beat changed");

    // The input side can only back up once the result register is full.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !tick_stall)
        else $error("tick stalled with an empty result register");

    // No unused state code ever leaves the block.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sequence_step <= 4'd12)
        else $error("sequence step out of range");

    // Nothing is offered straight out of reset.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result offered after reset");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_stall    (tick_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .unlocked      (unlocked),
    .sequence_step (sequence_step)
);

`default_nettype wire
